/* rtl/xtt_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// xtt_pkg: shared types and constants of the tag tokenizer
// Character classes passed from the front end to the back end, the grammar
// phases, the event codes and the escape patterns.
// -----------------------------------------------------------------------------
package xtt_pkg;

   // Class of one request as seen by the grammar
   typedef enum logic [3:0] {
      CC_WS,      // whitespace: 9..13 and space
      CC_LT,      // '<'
      CC_GT,      // '>'
      CC_SLASH,   // '/'
      CC_NAME,    // letter, digit or '-'
      CC_EQ,      // '='
      CC_QUOTE,   // '"'
      CC_AMP,     // '&'
      CC_SEMI,    // ';'
      CC_MARK,    // '!' or '?'
      CC_OTHER,   // any other byte
      CC_END      // end of input, no byte
   } cls_type;

   // One classified request as it sits in the queue
   typedef struct packed {
      logic [7:0] char_v;
      cls_type    cls;
   } tok_type;

   // Position in the tag grammar
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_LT,
      PH_TAGNAME,
      PH_ATTRS,
      PH_ANAME,
      PH_PREEQ,
      PH_POSTEQ,
      PH_VALUE,
      PH_ESC,
      PH_SLASH,
      PH_ENAME,
      PH_EWS,
      PH_SKIP
   } phase_type;

   // Event codes on the result channel
   typedef enum logic [3:0] {
      EV_TAGCH  = 4'd0,
      EV_ENDCH  = 4'd1,
      EV_ATTRCH = 4'd2,
      EV_VALCH  = 4'd3,
      EV_START  = 4'd4,
      EV_EMPTY  = 4'd5,
      EV_ENDTAG = 4'd6,
      EV_ATTR   = 4'd7,
      EV_ERROR  = 4'd8,
      EV_EOS    = 4'd9
   } event_type;

   // Escape bodies, newest character in the low byte
   localparam logic [23:0] ESC_LT  = 24'h00_6C_74;   // "lt"
   localparam logic [23:0] ESC_GT  = 24'h00_67_74;   // "gt"
   localparam logic [23:0] ESC_AMP = 24'h61_6D_70;   // "amp"
   localparam logic [1:0]  ESC_MAX = 2'd3;

   localparam logic [7:0] CH_LT  = 8'h3C;
   localparam logic [7:0] CH_GT  = 8'h3E;
   localparam logic [7:0] CH_AMP = 8'h26;

endpackage

/* rtl/xtt_front.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// xtt_front: request classifier
// Sorts each incoming byte, or the end marker, into a grammar class.
// -----------------------------------------------------------------------------
module xtt_front
   import xtt_pkg::*;
(
   input  logic [7:0] byte_in,
   input  logic       is_end,
   output tok_type    tok
);

   cls_type cls;

   always_comb begin
      if (is_end) begin
         cls = CC_END;
      end else begin
         case (byte_in) inside
            8'd32, [8'd9:8'd13]:                    cls = CC_WS;
            8'h3C:                                  cls = CC_LT;
            8'h3E:                                  cls = CC_GT;
            8'h2F:                                  cls = CC_SLASH;
            ["a":"z"], ["A":"Z"], ["0":"9"], 8'h2D: cls = CC_NAME;
            8'h3D:                                  cls = CC_EQ;
            8'h22:                                  cls = CC_QUOTE;
            8'h26:                                  cls = CC_AMP;
            8'h3B:                                  cls = CC_SEMI;
            8'h21, 8'h3F:                           cls = CC_MARK;
            default:                                cls = CC_OTHER;
         endcase
      end
   end

   assign tok.char_v = byte_in;
   assign tok.cls    = cls;

endmodule

/* rtl/xtt_queue.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// xtt_queue: small request queue
// Holds classified requests between the front end and the back end.
// -----------------------------------------------------------------------------
module xtt_queue
   import xtt_pkg::*;
#(
   parameter int DEPTH = 2
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  tok_type push_tok,
   output logic    not_full,
   input  logic    pop,
   output logic    not_empty,
   output tok_type pop_tok
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tok_type            mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign not_full  = (count_ff != CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_tok   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/xtt_back.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// xtt_back: grammar engine and result register
// Runs the tag grammar on one classified request per cycle while the result
// register is free or emptying, decodes escapes and holds events until taken.
// -----------------------------------------------------------------------------
module xtt_back
   import xtt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       tok_valid,
   input  tok_type    tok,
   output logic       tok_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_event_res,
   output logic [7:0] rsp_char_value
);

   phase_type   phase_ff, phase_in;
   logic [23:0] ebuf_ff, ebuf_in;
   logic [1:0]  ecnt_ff, ecnt_in;
   logic        err_ff, err_in;

   logic        rsp_valid_ff;
   event_type   ev_ff;
   logic [7:0]  ch_ff;

   logic        hit, fail;
   event_type   ev;
   logic [7:0]  ch;

   // outcome of a character in attribute position, shared by several phases
   phase_type   a_phase;
   logic        a_hit, a_fail;
   event_type   a_ev;

   assign tok_pop = tok_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      a_phase = PH_ATTRS;
      a_hit   = 1'b0;
      a_fail  = 1'b0;
      a_ev    = EV_ERROR;
      case (tok.cls)
         CC_WS:    a_phase = PH_ATTRS;
         CC_SLASH: a_phase = PH_SLASH;
         CC_GT: begin
            a_phase = PH_IDLE;
            a_hit   = 1'b1;
            a_ev    = EV_START;
         end
         CC_NAME: begin
            a_phase = PH_ANAME;
            a_hit   = 1'b1;
            a_ev    = EV_ATTRCH;
         end
         CC_EQ:    a_phase = PH_POSTEQ;
         default:  a_fail  = 1'b1;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      ebuf_in  = ebuf_ff;
      ecnt_in  = ecnt_ff;
      err_in   = err_ff;
      hit      = 1'b0;
      fail     = 1'b0;
      ev       = EV_ERROR;
      ch       = '0;

      if (err_ff) begin
         hit = 1'b1;
      end else if (tok.cls == CC_END) begin
         if (phase_ff == PH_IDLE) begin
            hit = 1'b1;
            ev  = EV_EOS;
         end else begin
            fail = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (tok.cls == CC_LT) begin
                  phase_in = PH_LT;
               end else if (tok.cls != CC_WS) begin
                  fail = 1'b1;
               end
            end
            PH_LT, PH_TAGNAME: begin
               if (phase_ff == PH_LT && tok.cls == CC_SLASH) begin
                  phase_in = PH_ENAME;
               end else if (phase_ff == PH_LT && tok.cls == CC_MARK) begin
                  phase_in = PH_SKIP;
               end else if (tok.cls == CC_NAME) begin
                  phase_in = PH_TAGNAME;
                  hit      = 1'b1;
                  ev       = EV_TAGCH;
                  ch       = tok.char_v;
               end else begin
                  phase_in = a_phase;
                  hit      = a_hit;
                  fail     = a_fail;
                  ev       = a_ev;
                  ch       = (a_ev == EV_ATTRCH) ? tok.char_v : '0;
               end
            end
            PH_ATTRS: begin
               phase_in = a_phase;
               hit      = a_hit;
               fail     = a_fail;
               ev       = a_ev;
               ch       = (a_ev == EV_ATTRCH) ? tok.char_v : '0;
            end
            PH_ANAME: begin
               case (tok.cls)
                  CC_NAME: begin
                     hit = 1'b1;
                     ev  = EV_ATTRCH;
                     ch  = tok.char_v;
                  end
                  CC_WS:   phase_in = PH_PREEQ;
                  CC_EQ:   phase_in = PH_POSTEQ;
                  default: fail     = 1'b1;
               endcase
            end
            PH_PREEQ: begin
               if (tok.cls == CC_EQ) begin
                  phase_in = PH_POSTEQ;
               end else if (tok.cls != CC_WS) begin
                  fail = 1'b1;
               end
            end
            PH_POSTEQ: begin
               if (tok.cls == CC_QUOTE) begin
                  phase_in = PH_VALUE;
               end else if (tok.cls != CC_WS) begin
                  fail = 1'b1;
               end
            end
            PH_VALUE: begin
               if (tok.cls == CC_QUOTE) begin
                  phase_in = PH_ATTRS;
                  hit      = 1'b1;
                  ev       = EV_ATTR;
               end else if (tok.cls == CC_AMP) begin
                  phase_in = PH_ESC;
                  ebuf_in  = '0;
                  ecnt_in  = '0;
               end else begin
                  hit = 1'b1;
                  ev  = EV_VALCH;
                  ch  = tok.char_v;
               end
            end
            PH_ESC: begin
               if (tok.cls == CC_SEMI) begin
                  // decode the collected escape body
                  if (ecnt_ff == 2'd2 && ebuf_ff == ESC_LT) begin
                     ch = CH_LT;
                  end else if (ecnt_ff == 2'd2 && ebuf_ff == ESC_GT) begin
                     ch = CH_GT;
                  end else if (ecnt_ff == ESC_MAX && ebuf_ff == ESC_AMP) begin
                     ch = CH_AMP;
                  end else begin
                     fail = 1'b1;
                  end
                  phase_in = PH_VALUE;
                  ebuf_in  = '0;
                  ecnt_in  = '0;
                  hit      = 1'b1;
                  ev       = EV_VALCH;
               end else if (ecnt_ff == ESC_MAX) begin
                  fail = 1'b1;
               end else begin
                  ebuf_in = {ebuf_ff[15:0], tok.char_v};
                  ecnt_in = ecnt_ff + 1'b1;
               end
            end
            PH_SLASH: begin
               if (tok.cls == CC_GT) begin
                  phase_in = PH_IDLE;
                  hit      = 1'b1;
                  ev       = EV_EMPTY;
               end else begin
                  fail = 1'b1;
               end
            end
            PH_ENAME, PH_EWS: begin
               if (phase_ff == PH_ENAME && tok.cls == CC_NAME) begin
                  hit = 1'b1;
                  ev  = EV_ENDCH;
                  ch  = tok.char_v;
               end else if (tok.cls == CC_WS) begin
                  phase_in = PH_EWS;
               end else if (tok.cls == CC_GT) begin
                  phase_in = PH_IDLE;
                  hit      = 1'b1;
                  ev       = EV_ENDTAG;
               end else begin
                  fail = 1'b1;
               end
            end
            PH_SKIP: begin
               if (tok.cls == CC_GT) begin
                  phase_in = PH_IDLE;
               end
            end
            default: fail = 1'b1;
         endcase
      end

      if (fail) begin
         hit    = 1'b1;
         ev     = EV_ERROR;
         ch     = '0;
         err_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         ebuf_ff      <= '0;
         ecnt_ff      <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (tok_pop) begin
            phase_ff     <= phase_in;
            ebuf_ff      <= ebuf_in;
            ecnt_ff      <= ecnt_in;
            err_ff       <= err_in;
            rsp_valid_ff <= hit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tok_pop) begin
         ev_ff <= ev;
         ch_ff <= ch;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_res  = ev_ff;
   assign rsp_char_value = ch_ff;

endmodule

/* rtl/xml_tag_tokenizer.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// xml_tag_tokenizer: byte-serial tokenizer for tag-only XML
// Recognises start, end and empty-element tags with double-quoted attributes,
// reports each name or value character as it arrives, decodes the lt, gt and
// amp escapes and skips markup that opens with "<!" or "<?".
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid/req_ready    req_byte_in[7:0], req_is_end
//   rsp       out        rsp_valid/rsp_ready    rsp_event_res[3:0], rsp_char_value[7:0]
//
// Cycles: one request per clock sustained; a request is written into the queue
//   and then passes through the grammar engine into the result register, which
//   presents its event, if it has one, on rsp.
// The rate is set by the grammar engine, which retires one queued request a
//   cycle whenever the result register is free or being emptied.
// Reset: synchronous, active high; clears the queue, the phase, the escape
//   state and the sticky error flag.
// Stalls: a held rsp_ready stops the engine only; the queue keeps taking
//   requests until it is full, then drops req_ready.
// -----------------------------------------------------------------------------
module xml_tag_tokenizer
   import xtt_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_in,
   input  logic       req_is_end,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_event_res,
   output logic [7:0] rsp_char_value
);

   tok_type in_tok;    // classified request from the front end
   tok_type q_tok;     // oldest request in the queue
   logic    q_not_full;
   logic    q_not_empty;
   logic    q_pop;

   // Classify the byte as it arrives
   xtt_front u_front (
      .byte_in (req_byte_in),
      .is_end  (req_is_end),
      .tok     (in_tok)
   );

   // Hold classified requests; readiness comes from the fill level alone
   assign req_ready = q_not_full;

   xtt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && q_not_full),
      .push_tok  (in_tok),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_tok   (q_tok)
   );

   // Advance the grammar and register the event
   xtt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .tok_valid      (q_not_empty),
      .tok            (q_tok),
      .tok_pop        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_res  (rsp_event_res),
      .rsp_char_value (rsp_char_value)
   );

endmodule
